/* hdl/tkd_pkg.sv */
// terminal key decoder package: parser mode encoding, key codes, result and state types
// no dependencies; used by tkd_step and terminal_key_decoder_top
package tkd_pkg;

    typedef enum logic [5:0] {
        MODE_GROUND = 6'b000001,
        MODE_ESC    = 6'b000010,
        MODE_CSI    = 6'b000100,
        MODE_SS3    = 6'b001000,
        MODE_UTF8   = 6'b010000,
        MODE_MOUSE  = 6'b100000
    } t_mode;

    localparam logic [4:0] K_NONE   = 5'd0;
    localparam logic [4:0] K_UP     = 5'd1;
    localparam logic [4:0] K_DOWN   = 5'd2;
    localparam logic [4:0] K_RIGHT  = 5'd3;
    localparam logic [4:0] K_LEFT   = 5'd4;
    localparam logic [4:0] K_HOME   = 5'd5;
    localparam logic [4:0] K_END    = 5'd6;
    localparam logic [4:0] K_INS    = 5'd7;
    localparam logic [4:0] K_DEL    = 5'd8;
    localparam logic [4:0] K_PGUP   = 5'd9;
    localparam logic [4:0] K_PGDN   = 5'd10;
    localparam logic [4:0] K_F1     = 5'd11;
    localparam logic [4:0] K_ESCAPE = 5'd23;
    localparam logic [4:0] K_TAB    = 5'd24;
    localparam logic [4:0] K_ENTER  = 5'd25;
    localparam logic [4:0] K_BKSP   = 5'd26;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    typedef struct packed {
        logic [4:0]  key_code;
        logic [20:0] code_point;
        logic        alt_flag;
        logic        ctrl_flag;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  csi_number;
        logic        csi_digits_ended;
        logic        csi_has_params;
        logic [20:0] utf8_value;
        logic [1:0]  utf8_left;
        logic [1:0]  utf8_length;
        logic [7:0]  mouse_bytes;
    } t_state;

endpackage

/* hdl/tkd_step.sv */
// terminal key decoder single step: next parser state and optional key word for one item
// depends on tkd_pkg
module tkd_step #(
    parameter int MOUSE_LIMIT = 128
) (
    input  tkd_pkg::t_state  i_state,
    input  logic             i_operation,
    input  logic [7:0]       i_data_byte,
    output tkd_pkg::t_state  o_state,
    output logic             o_emit,
    output tkd_pkg::t_result o_result
);

    typedef struct packed {
        logic             emit;
        tkd_pkg::t_result res;
        logic             to_esc;
        logic             to_utf8;
        logic [1:0]       len;
        logic [20:0]      val;
    } t_ground;

    function automatic tkd_pkg::t_result key_only(input logic [4:0] k);
        tkd_pkg::t_result r;
        r = '0;
        r.key_code = k;
        return r;
    endfunction

    function automatic tkd_pkg::t_result char_res(input logic [7:0] c, input logic alt,
                                                  input logic ctrl);
        tkd_pkg::t_result r;
        r = '0;
        r.code_point = {13'd0, c};
        r.alt_flag   = alt;
        r.ctrl_flag  = ctrl;
        return r;
    endfunction

    function automatic t_ground ground_byte(input logic [7:0] b);
        t_ground g;
        g = '0;
        priority if (b == 8'h1B) begin
            g.to_esc = 1'b1;
        end else if (b == 8'h09) begin
            g.emit = 1'b1;
            g.res  = key_only(tkd_pkg::K_TAB);
        end else if (b == 8'h0D) begin
            g.emit = 1'b1;
            g.res  = key_only(tkd_pkg::K_ENTER);
        end else if (b == 8'h7F) begin
            g.emit = 1'b1;
            g.res  = key_only(tkd_pkg::K_BKSP);
        end else if (b >= 8'h20 && b <= 8'h7E) begin
            g.emit = 1'b1;
            g.res  = char_res(b, 1'b0, 1'b0);
        end else if (b >= 8'hC2 && b <= 8'hF7) begin
            g.to_utf8 = 1'b1;
            if (b < 8'hE0) begin
                g.len = 2'd1;
                g.val = {16'd0, b[4:0]};
            end else if (b < 8'hF0) begin
                g.len = 2'd2;
                g.val = {17'd0, b[3:0]};
            end else begin
                g.len = 2'd3;
                g.val = {18'd0, b[2:0]};
            end
        end else if (b == 8'h00) begin
            g.emit = 1'b1;
            g.res  = char_res(8'h20, 1'b0, 1'b1);
        end else if (b <= 8'h1A) begin
            // control letters map to lower case
            g.emit = 1'b1;
            g.res  = char_res(b + 8'h60, 1'b0, 1'b1);
        end else if (b >= 8'h1C && b <= 8'h1F) begin
            g.emit = 1'b1;
            g.res  = char_res(b + 8'h40, 1'b0, 1'b1);
        end else begin
            // stray bytes are discarded
            g.emit = 1'b0;
        end
        return g;
    endfunction

    function automatic logic [4:0] tilde_key(input logic [7:0] n);
        logic [4:0] k;
        case (n)
            8'd1:    k = tkd_pkg::K_HOME;
            8'd2:    k = tkd_pkg::K_INS;
            8'd3:    k = tkd_pkg::K_DEL;
            8'd4:    k = tkd_pkg::K_END;
            8'd5:    k = tkd_pkg::K_PGUP;
            8'd6:    k = tkd_pkg::K_PGDN;
            8'd11:   k = tkd_pkg::K_F1;
            8'd12:   k = tkd_pkg::K_F1 + 5'd1;
            8'd13:   k = tkd_pkg::K_F1 + 5'd2;
            8'd14:   k = tkd_pkg::K_F1 + 5'd3;
            8'd15:   k = tkd_pkg::K_F1 + 5'd4;
            8'd17:   k = tkd_pkg::K_F1 + 5'd5;
            8'd18:   k = tkd_pkg::K_F1 + 5'd6;
            8'd19:   k = tkd_pkg::K_F1 + 5'd7;
            8'd20:   k = tkd_pkg::K_F1 + 5'd8;
            8'd21:   k = tkd_pkg::K_F1 + 5'd9;
            8'd23:   k = tkd_pkg::K_F1 + 5'd10;
            8'd24:   k = tkd_pkg::K_F1 + 5'd11;
            default: k = tkd_pkg::K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] csi_key(input logic [7:0] t, input logic has_params,
                                           input logic [7:0] n);
        logic [4:0] k;
        k = tkd_pkg::K_NONE;
        if (!has_params) begin
            case (t)
                8'h41:   k = tkd_pkg::K_UP;
                8'h42:   k = tkd_pkg::K_DOWN;
                8'h43:   k = tkd_pkg::K_RIGHT;
                8'h44:   k = tkd_pkg::K_LEFT;
                8'h48:   k = tkd_pkg::K_HOME;
                8'h46:   k = tkd_pkg::K_END;
                default: k = tkd_pkg::K_NONE;
            endcase
        end
        if (t == 8'h7E && k == tkd_pkg::K_NONE) begin
            k = tilde_key(n);
        end
        return k;
    endfunction

    localparam logic [7:0] MouseLimit = 8'(MOUSE_LIMIT);

    t_ground     w_gnd;
    logic [11:0] w_csi_prod;
    logic [20:0] w_utf8_val;
    logic [1:0]  w_utf8_left;
    logic [20:0] w_utf8_min;

    assign w_gnd       = ground_byte(i_data_byte);
    assign w_csi_prod  = 12'(i_state.csi_number) * 12'd10 + 12'(i_data_byte[3:0]);
    assign w_utf8_val  = {i_state.utf8_value[14:0], i_data_byte[5:0]};
    assign w_utf8_left = i_state.utf8_left - 2'd1;

    always_comb begin
        unique case (i_state.utf8_length)
            2'd1:    w_utf8_min = 21'h80;
            2'd2:    w_utf8_min = 21'h800;
            default: w_utf8_min = 21'h10000;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;

        if (i_operation == tkd_pkg::OP_IDLE) begin
            if (i_state.mode == tkd_pkg::MODE_ESC) begin
                o_state.mode = tkd_pkg::MODE_GROUND;
                o_emit       = 1'b1;
                o_result     = key_only(tkd_pkg::K_ESCAPE);
            end
        end else begin
            unique case (i_state.mode)
                tkd_pkg::MODE_ESC: begin
                    if (i_data_byte == 8'h5B) begin
                        o_state.csi_number       = '0;
                        o_state.csi_digits_ended = 1'b0;
                        o_state.csi_has_params   = 1'b0;
                        o_state.mode             = tkd_pkg::MODE_CSI;
                    end else if (i_data_byte == 8'h4F) begin
                        o_state.mode = tkd_pkg::MODE_SS3;
                    end else if (i_data_byte >= 8'h20 && i_data_byte <= 8'h7E) begin
                        o_state.mode = tkd_pkg::MODE_GROUND;
                        o_emit       = 1'b1;
                        o_result     = char_res(i_data_byte, 1'b1, 1'b0);
                    end else begin
                        // non-printable after esc: esc dropped, byte decoded afresh
                        o_emit   = w_gnd.emit;
                        o_result = w_gnd.res;
                        if (w_gnd.to_esc) begin
                            o_state.mode = tkd_pkg::MODE_ESC;
                        end else if (w_gnd.to_utf8) begin
                            o_state.mode        = tkd_pkg::MODE_UTF8;
                            o_state.utf8_length = w_gnd.len;
                            o_state.utf8_left   = w_gnd.len;
                            o_state.utf8_value  = w_gnd.val;
                        end else begin
                            o_state.mode = tkd_pkg::MODE_GROUND;
                        end
                    end
                end
                tkd_pkg::MODE_CSI: begin
                    if (!i_state.csi_has_params && i_data_byte == 8'h3C) begin
                        o_state.mode        = tkd_pkg::MODE_MOUSE;
                        o_state.mouse_bytes = 8'd3;
                    end else if (i_data_byte >= 8'h40 && i_data_byte <= 8'h7E) begin
                        o_state.mode = tkd_pkg::MODE_GROUND;
                        o_emit       = 1'b1;
                        o_result     = key_only(csi_key(i_data_byte, i_state.csi_has_params,
                                                        i_state.csi_number));
                    end else begin
                        o_state.csi_has_params = 1'b1;
                        if (!i_state.csi_digits_ended) begin
                            if (i_data_byte >= 8'h30 && i_data_byte <= 8'h39) begin
                                o_state.csi_number = (w_csi_prod > 12'd255) ? 8'd255
                                                                           : w_csi_prod[7:0];
                            end else begin
                                o_state.csi_digits_ended = 1'b1;
                            end
                        end
                    end
                end
                tkd_pkg::MODE_SS3: begin
                    o_state.mode = tkd_pkg::MODE_GROUND;
                    o_emit       = 1'b1;
                    if (i_data_byte >= 8'h50 && i_data_byte <= 8'h53) begin
                        o_result = key_only(tkd_pkg::K_F1 + {3'd0, i_data_byte[1:0]});
                    end
                end
                tkd_pkg::MODE_UTF8: begin
                    if (i_data_byte[7:6] != 2'b10) begin
                        // bad continuation: drop sequence, decode byte in ground
                        o_emit   = w_gnd.emit;
                        o_result = w_gnd.res;
                        if (w_gnd.to_esc) begin
                            o_state.mode = tkd_pkg::MODE_ESC;
                        end else if (w_gnd.to_utf8) begin
                            o_state.mode        = tkd_pkg::MODE_UTF8;
                            o_state.utf8_length = w_gnd.len;
                            o_state.utf8_left   = w_gnd.len;
                            o_state.utf8_value  = w_gnd.val;
                        end else begin
                            o_state.mode = tkd_pkg::MODE_GROUND;
                        end
                    end else begin
                        o_state.utf8_value = w_utf8_val;
                        o_state.utf8_left  = w_utf8_left;
                        if (w_utf8_left == 2'd0) begin
                            o_state.mode = tkd_pkg::MODE_GROUND;
                            // overlong forms give nothing
                            if (w_utf8_val >= w_utf8_min) begin
                                o_emit              = 1'b1;
                                o_result.code_point = w_utf8_val;
                            end
                        end
                    end
                end
                tkd_pkg::MODE_MOUSE: begin
                    if (i_data_byte == 8'h4D || i_data_byte == 8'h6D) begin
                        o_state.mode = tkd_pkg::MODE_GROUND;
                    end else if (i_state.mouse_bytes >= MouseLimit) begin
                        o_state.mode        = tkd_pkg::MODE_GROUND;
                        o_state.mouse_bytes = '0;
                    end else begin
                        o_state.mouse_bytes = i_state.mouse_bytes + 8'd1;
                    end
                end
                default: begin
                    o_emit   = w_gnd.emit;
                    o_result = w_gnd.res;
                    if (w_gnd.to_esc) begin
                        o_state.mode = tkd_pkg::MODE_ESC;
                    end else if (w_gnd.to_utf8) begin
                        o_state.mode        = tkd_pkg::MODE_UTF8;
                        o_state.utf8_length = w_gnd.len;
                        o_state.utf8_left   = w_gnd.len;
                        o_state.utf8_value  = w_gnd.val;
                    end else begin
                        o_state.mode = tkd_pkg::MODE_GROUND;
                    end
                end
            endcase
        end
    end

endmodule

/* hdl/terminal_key_decoder_top.sv */
// terminal key decoder top level: input register, parser state, result register
// depends on tkd_pkg and tkd_step
//
// Decodes a terminal byte stream into key words. One item (a byte or an idle mark) is taken
// every clock cycle unless the input is stalled; an item's key word, if it has one, goes from
// the input register through the combinational parser step into the result register.
// The idle mark turns a pending lone ESC into the Escape key.
// Input is stalled only while a result is waiting in the full result register and the
// item in the input register also has a result. MOUSE_LIMIT (8 to 255) is the longest
// mouse report, counting ESC [ <, that is swallowed before the parser gives up on it.
module terminal_key_decoder_top #(
    parameter int MOUSE_LIMIT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_key_code,
    output logic [20:0] o_code_point,
    output logic        o_alt_flag,
    output logic        o_ctrl_flag
);

    logic             r_in_valid;
    logic             r_in_op;
    logic [7:0]       r_in_byte;
    tkd_pkg::t_state  r_state;
    tkd_pkg::t_state  n_state;
    logic             r_out_valid;
    tkd_pkg::t_result r_out;
    tkd_pkg::t_result n_out;
    logic             w_emit;
    logic             w_out_free;
    logic             w_adv;
    logic             w_accept;

    tkd_step #(
        .MOUSE_LIMIT(MOUSE_LIMIT)
    ) u_step (
        .i_state    (r_state),
        .i_operation(r_in_op),
        .i_data_byte(r_in_byte),
        .o_state    (n_state),
        .o_emit     (w_emit),
        .o_result   (n_out)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    // an item without a result never waits for the output side
    assign w_adv      = r_in_valid && (!w_emit || w_out_free);
    assign o_stall    = r_in_valid && !w_adv;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: tkd_pkg::MODE_GROUND, csi_number: 8'd0,
                         csi_digits_ended: 1'b0, csi_has_params: 1'b0,
                         utf8_value: 21'd0, utf8_left: 2'd0, utf8_length: 2'd0,
                         mouse_bytes: 8'd0};
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_code   = r_out.key_code;
    assign o_code_point = r_out.code_point;
    assign o_alt_flag   = r_out.alt_flag;
    assign o_ctrl_flag  = r_out.ctrl_flag;

endmodule

/* tb/sv/terminal_key_decoder_top_tb.sv */
// self-checking testbench for terminal_key_decoder_top: a directed table of bytes, then a
// random stream of well-formed and broken escape, utf-8 and mouse sequences, with idling
// on both sides; depends on tkd_pkg and terminal_key_decoder_top
module terminal_key_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOUSE_MAX = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_A_BYTES = 450;
    localparam int PHASE_B_BYTES = 800;
    localparam int TOTAL_BYTES = 1350;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CSI_BYTE = 8'h5B;
    localparam logic [7:0] SS3_BYTE = 8'h4F;
    localparam logic [7:0] MOUSE_BYTE = 8'h3C;
    localparam logic [7:0] TILDE_BYTE = 8'h7E;

    typedef struct packed {
        logic             op;
        logic [7:0]       data;
        logic             typed;
        logic             has;
        tkd_pkg::t_result key;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = tkd_pkg::OP_BYTE;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_key_code;
    logic [20:0] o_code_point;
    logic        o_alt_flag;
    logic        o_ctrl_flag;

    // decoder state mirrored by the predictor
    tkd_pkg::t_mode dec_mode = tkd_pkg::MODE_GROUND;
    logic [7:0]  dec_csi_num = '0;
    logic        dec_csi_ended = 1'b0;
    logic        dec_csi_params = 1'b0;
    logic [20:0] dec_utf_value = '0;
    logic [1:0]  dec_utf_left = '0;
    logic [1:0]  dec_utf_len = '0;
    logic [7:0]  dec_mouse_len = '0;

    tkd_pkg::t_result pending_keys [$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    int          rx_odds = 0;
    bit          tx_gaps = 1'b0;
    bit          hold_req = 1'b0;

    // side band for the word on offer: typed-in expectation from the table
    logic        row_typed = 1'b0;
    logic        row_has = 1'b0;
    tkd_pkg::t_result row_key = '0;

    t_stim_row dir_rows [27] = '{
        '{tkd_pkg::OP_IDLE, 8'h00, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h00, 1'b1, 1'b1, '{tkd_pkg::K_NONE, 21'h20, 1'b0, 1'b1}},
        '{tkd_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h7F, 1'b1, 1'b1, '{tkd_pkg::K_BKSP, 21'h0, 1'b0, 1'b0}},
        '{tkd_pkg::OP_BYTE, ESC_BYTE, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_IDLE, 8'hA5, 1'b1, 1'b1, '{tkd_pkg::K_ESCAPE, 21'h0, 1'b0, 1'b0}},
        '{tkd_pkg::OP_BYTE, ESC_BYTE, 1'b1, 1'b0, '0},
        // non-printable after esc: esc dropped, tab decoded as usual
        '{tkd_pkg::OP_BYTE, 8'h09, 1'b1, 1'b1, '{tkd_pkg::K_TAB, 21'h0, 1'b0, 1'b0}},
        '{tkd_pkg::OP_BYTE, ESC_BYTE, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h7E, 1'b1, 1'b1, '{tkd_pkg::K_NONE, 21'h7E, 1'b1, 1'b0}},
        '{tkd_pkg::OP_BYTE, ESC_BYTE, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, CSI_BYTE, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h32, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h34, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, TILDE_BYTE, 1'b1, 1'b1,
          '{tkd_pkg::K_F1 + 5'd11, 21'h0, 1'b0, 1'b0}},
        '{tkd_pkg::OP_BYTE, ESC_BYTE, 1'b1, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, SS3_BYTE, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h53, 1'b1, 1'b1, '{tkd_pkg::K_F1 + 5'd3, 21'h0, 1'b0, 1'b0}},
        // largest four-byte value, above the unicode range
        '{tkd_pkg::OP_BYTE, 8'hF7, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'hBF, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'hBF, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'hBF, 1'b1, 1'b1, '{tkd_pkg::K_NONE, 21'h1FFFFF, 1'b0, 1'b0}},
        // overlong three-byte form
        '{tkd_pkg::OP_BYTE, 8'hE0, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h80, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h80, 1'b1, 1'b0, '0},
        // broken continuation: lead dropped, byte decoded in ground mode
        '{tkd_pkg::OP_BYTE, 8'hC3, 1'b0, 1'b0, '0},
        '{tkd_pkg::OP_BYTE, 8'h41, 1'b1, 1'b1, '{tkd_pkg::K_NONE, 21'h41, 1'b0, 1'b0}}
    };

    terminal_key_decoder_top #(
        .MOUSE_LIMIT(MOUSE_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_key_code   (o_key_code),
        .o_code_point (o_code_point),
        .o_alt_flag   (o_alt_flag),
        .o_ctrl_flag  (o_ctrl_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 75) return $urandom_range(3, 1);
        if (roll < 95) return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic bit ground_key(input logic [7:0] b, output tkd_pkg::t_result r);
        r = '0;
        if (b == ESC_BYTE) begin
            dec_mode = tkd_pkg::MODE_ESC;
            return 1'b0;
        end
        if (b == 8'h09) begin
            r.key_code = tkd_pkg::K_TAB;
            return 1'b1;
        end
        if (b == 8'h0D) begin
            r.key_code = tkd_pkg::K_ENTER;
            return 1'b1;
        end
        if (b == 8'h7F) begin
            r.key_code = tkd_pkg::K_BKSP;
            return 1'b1;
        end
        if (b >= 8'h20 && b <= 8'h7E) begin
            r.code_point = 21'(b);
            return 1'b1;
        end
        if (b >= 8'hC2 && b <= 8'hF7) begin
            if (b < 8'hE0) begin
                dec_utf_len = 2'd1;
                dec_utf_value = 21'(b[4:0]);
            end else if (b < 8'hF0) begin
                dec_utf_len = 2'd2;
                dec_utf_value = 21'(b[3:0]);
            end else begin
                dec_utf_len = 2'd3;
                dec_utf_value = 21'(b[2:0]);
            end
            dec_utf_left = dec_utf_len;
            dec_mode = tkd_pkg::MODE_UTF8;
            return 1'b0;
        end
        r.ctrl_flag = 1'b1;
        if (b == 8'h00) begin
            r.code_point = 21'h20;
            return 1'b1;
        end
        if (b <= 8'h1A) begin
            r.code_point = 21'h60 + 21'(b);
            return 1'b1;
        end
        if (b >= 8'h1C && b <= 8'h1F) begin
            r.code_point = 21'h5C + 21'(b - 8'h1C);
            return 1'b1;
        end
        r = '0;
        return 1'b0;
    endfunction

    function automatic logic [4:0] csi_final_key(input logic [7:0] fin);
        if (!dec_csi_params) begin
            case (fin)
                "A": return tkd_pkg::K_UP;
                "B": return tkd_pkg::K_DOWN;
                "C": return tkd_pkg::K_RIGHT;
                "D": return tkd_pkg::K_LEFT;
                "H": return tkd_pkg::K_HOME;
                "F": return tkd_pkg::K_END;
                default: ;
            endcase
        end
        if (fin == TILDE_BYTE) begin
            case (dec_csi_num)
                8'd1: return tkd_pkg::K_HOME;
                8'd2: return tkd_pkg::K_INS;
                8'd3: return tkd_pkg::K_DEL;
                8'd4: return tkd_pkg::K_END;
                8'd5: return tkd_pkg::K_PGUP;
                8'd6: return tkd_pkg::K_PGDN;
                8'd11, 8'd12, 8'd13, 8'd14, 8'd15:
                    return tkd_pkg::K_F1 + 5'(dec_csi_num - 8'd11);
                8'd17, 8'd18, 8'd19, 8'd20, 8'd21:
                    return tkd_pkg::K_F1 + 5'd5 + 5'(dec_csi_num - 8'd17);
                8'd23, 8'd24: return tkd_pkg::K_F1 + 5'd10 + 5'(dec_csi_num - 8'd23);
                default: ;
            endcase
        end
        return tkd_pkg::K_NONE;
    endfunction

    // advances the mirrored state by one word; returns 1 when a key word follows
    function automatic bit decode_item(input logic op, input logic [7:0] b,
                                       output tkd_pkg::t_result r);
        int          grown;
        logic [20:0] floor_cp;
        r = '0;
        if (op == tkd_pkg::OP_IDLE) begin
            if (dec_mode == tkd_pkg::MODE_ESC) begin
                dec_mode = tkd_pkg::MODE_GROUND;
                r.key_code = tkd_pkg::K_ESCAPE;
                return 1'b1;
            end
            return 1'b0;
        end
        case (dec_mode)
            tkd_pkg::MODE_ESC: begin
                if (b == CSI_BYTE) begin
                    dec_csi_num = '0;
                    dec_csi_ended = 1'b0;
                    dec_csi_params = 1'b0;
                    dec_mode = tkd_pkg::MODE_CSI;
                    return 1'b0;
                end
                if (b == SS3_BYTE) begin
                    dec_mode = tkd_pkg::MODE_SS3;
                    return 1'b0;
                end
                dec_mode = tkd_pkg::MODE_GROUND;
                if (b >= 8'h20 && b <= 8'h7E) begin
                    r.code_point = 21'(b);
                    r.alt_flag = 1'b1;
                    return 1'b1;
                end
                return ground_key(b, r);
            end
            tkd_pkg::MODE_CSI: begin
                if (!dec_csi_params && b == MOUSE_BYTE) begin
                    dec_mode = tkd_pkg::MODE_MOUSE;
                    dec_mouse_len = 8'd3;
                    return 1'b0;
                end
                if (b >= 8'h40 && b <= 8'h7E) begin
                    dec_mode = tkd_pkg::MODE_GROUND;
                    r.key_code = csi_final_key(b);
                    return 1'b1;
                end
                dec_csi_params = 1'b1;
                if (!dec_csi_ended) begin
                    if (b >= 8'h30 && b <= 8'h39) begin
                        // key number saturates at 255
                        grown = int'(dec_csi_num) * 10 + int'(b - 8'h30);
                        dec_csi_num = grown > 255 ? 8'd255 : 8'(grown);
                    end else begin
                        dec_csi_ended = 1'b1;
                    end
                end
                return 1'b0;
            end
            tkd_pkg::MODE_SS3: begin
                if (b >= 8'h50 && b <= 8'h53) r.key_code = tkd_pkg::K_F1 + 5'(b - 8'h50);
                dec_mode = tkd_pkg::MODE_GROUND;
                return 1'b1;
            end
            tkd_pkg::MODE_UTF8: begin
                if (b[7:6] != 2'b10) begin
                    dec_mode = tkd_pkg::MODE_GROUND;
                    return ground_key(b, r);
                end
                dec_utf_value = {dec_utf_value[14:0], b[5:0]};
                dec_utf_left = dec_utf_left - 2'd1;
                if (dec_utf_left != 2'd0) return 1'b0;
                dec_mode = tkd_pkg::MODE_GROUND;
                case (dec_utf_len)
                    2'd1: floor_cp = 21'h80;
                    2'd2: floor_cp = 21'h800;
                    default: floor_cp = 21'h10000;
                endcase
                if (dec_utf_value < floor_cp) return 1'b0;
                r.code_point = dec_utf_value;
                return 1'b1;
            end
            tkd_pkg::MODE_MOUSE: begin
                if (b == "M" || b == "m") begin
                    dec_mode = tkd_pkg::MODE_GROUND;
                    return 1'b0;
                end
                if (int'(dec_mouse_len) + 1 > MOUSE_MAX) begin
                    dec_mode = tkd_pkg::MODE_GROUND;
                    dec_mouse_len = '0;
                    return 1'b0;
                end
                dec_mouse_len = dec_mouse_len + 8'd1;
                return 1'b0;
            end
            default: begin
                dec_mode = tkd_pkg::MODE_GROUND;
                return ground_key(b, r);
            end
        endcase
    endfunction

    task automatic flag_field(input string field, input logic [20:0] want,
                              input logic [20:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : key_checker
        tkd_pkg::t_result got;
        tkd_pkg::t_result want;
        tkd_pkg::t_result predicted;
        bit               produced;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_key_code, o_code_point, o_alt_flag, o_ctrl_flag};
                if (pending_keys.size() == 0) begin
                    fail_count++;
                    $error("key word with none expected: key_code %0d code_point 0x%0h",
                           got.key_code, got.code_point);
                end else begin
                    want = pending_keys.pop_front();
                    flag_field("key_code", 21'(want.key_code), 21'(got.key_code));
                    flag_field("code_point", want.code_point, got.code_point);
                    flag_field("alt_flag", 21'(want.alt_flag), 21'(got.alt_flag));
                    flag_field("ctrl_flag", 21'(want.ctrl_flag), 21'(got.ctrl_flag));
                end
            end
            if (i_valid && !o_stall) begin
                produced = decode_item(i_operation, i_data_byte, predicted);
                if (row_typed) begin
                    if (row_has) pending_keys.push_back(row_key);
                end else if (produced) begin
                    pending_keys.push_back(predicted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("terminal_key_decoder_top regression: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    always begin : receiver
        int span;
        @(negedge i_clk);
        if (hold_req) begin
            span = HOLD_CYCLES;
            hold_req = 1'b0;
        end else if (i_rst_n && $urandom_range(99, 0) < rx_odds) begin
            span = idle_len();
        end else begin
            span = 0;
        end
        if (span > 0) begin
            i_stall <= 1'b1;
            repeat (span) @(negedge i_clk);
        end
        i_stall <= 1'b0;
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_item(input logic op, input logic [7:0] data, input logic typed,
                             input logic has, input tkd_pkg::t_result key);
        int gap;
        gap = (tx_gaps && $urandom_range(99, 0) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        row_typed = typed;
        row_has = has;
        row_key = key;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] data);
        bytes_sent++;
        send_item(tkd_pkg::OP_BYTE, data, 1'b0, 1'b0, '0);
    endtask

    task automatic send_idle();
        send_item(tkd_pkg::OP_IDLE, 8'($urandom), 1'b0, 1'b0, '0);
    endtask

    task automatic csi_sequence();
        string      digits;
        int         shape;
        logic [7:0] fin;
        send_byte(ESC_BYTE);
        send_byte(CSI_BYTE);
        shape = $urandom_range(9, 0);
        if (shape >= 3 && shape < 8) begin
            if (shape == 7) begin
                // long digit runs can push the key number into saturation
                repeat ($urandom_range(5, 1)) send_byte(8'h30 + 8'($urandom_range(9, 0)));
            end else begin
                digits = $sformatf("%0d", $urandom_range(24, 1));
                for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
            end
            if ($urandom_range(3, 0) == 0) begin
                send_byte(";");
                send_byte(8'h30 + 8'($urandom_range(9, 0)));
            end
        end else if (shape >= 8) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(8'h3F, 8'h20)));
        end
        if ($urandom_range(4, 0) == 0) begin
            fin = 8'($urandom_range(8'h7E, 8'h40));
        end else if (shape >= 3) begin
            fin = TILDE_BYTE;
        end else begin
            case ($urandom_range(5, 0))
                4: fin = "H";
                5: fin = "F";
                default: fin = 8'h41 + 8'($urandom_range(3, 0));
            endcase
        end
        send_byte(fin);
    endtask

    task automatic mouse_report();
        send_byte(ESC_BYTE);
        send_byte(CSI_BYTE);
        send_byte(MOUSE_BYTE);
        if ($urandom_range(19, 0) == 0) begin
            // no terminator: a long run that may pass the limit and fall back to ground mode
            repeat ($urandom_range(MOUSE_MAX + 10, MOUSE_MAX - 6))
                send_byte(8'h30 + 8'($urandom_range(11, 0)));
        end else begin
            repeat ($urandom_range(12, 1))
                send_byte($urandom_range(15, 0) == 0 ? 8'($urandom)
                                                     : 8'h30 + 8'($urandom_range(11, 0)));
            send_byte($urandom_range(1, 0) ? 8'h4D : 8'h6D);
        end
    endtask

    task automatic utf8_sequence();
        int         len;
        logic [7:0] lead;
        len = $urandom_range(3, 1);
        case (len)
            1: lead = 8'($urandom_range(8'hDF, 8'hC2));
            2: lead = 8'($urandom_range(8'hEF, 8'hE0));
            default: lead = 8'($urandom_range(8'hF7, 8'hF0));
        endcase
        if (len > 1 && $urandom_range(4, 0) == 0) begin
            // overlong: smallest lead and a low first continuation
            send_byte(len == 2 ? 8'hE0 : 8'hF0);
            send_byte(8'h80 + 8'($urandom_range(len == 2 ? 31 : 15, 0)));
            len = len - 1;
        end else begin
            send_byte(lead);
        end
        repeat (len)
            send_byte($urandom_range(15, 0) == 0 ? 8'($urandom)
                                                 : 8'h80 + 8'($urandom_range(63, 0)));
    endtask

    task automatic random_sequence();
        int kind;
        kind = $urandom_range(99, 0);
        if (kind < 14) begin
            send_byte(8'($urandom_range(8'h7E, 8'h20)));
        end else if (kind < 20) begin
            send_byte(8'($urandom_range(8'h1F, 8'h00)));
        end else if (kind < 26) begin
            send_byte(ESC_BYTE);
            send_idle();
        end else if (kind < 34) begin
            send_byte(ESC_BYTE);
            send_byte($urandom_range(1, 0) ? 8'($urandom_range(8'h7E, 8'h20)) : 8'($urandom));
        end else if (kind < 52) begin
            csi_sequence();
        end else if (kind < 60) begin
            send_byte(ESC_BYTE);
            send_byte(SS3_BYTE);
            send_byte($urandom_range(4, 0) == 0 ? 8'($urandom)
                                                : 8'h50 + 8'($urandom_range(3, 0)));
        end else if (kind < 66) begin
            mouse_report();
        end else if (kind < 84) begin
            utf8_sequence();
        end else if (kind < 92) begin
            send_byte(8'($urandom));
        end else if (kind < 96) begin
            send_idle();
        end else begin
            send_byte(8'($urandom_range(8'hFF, 8'h80)));
        end
    endtask

    initial begin : stimulus
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        rx_odds = 20;
        tx_gaps = 1'b1;
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].has,
                      dir_rows[i].key);

        rx_odds = 25;
        while (bytes_sent < PHASE_A_BYTES) random_sequence();

        // long hold-off on the result side while printable words keep coming
        tx_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom_range(8'h7E, 8'h20)));

        rx_odds = 0;
        while (bytes_sent < PHASE_B_BYTES) random_sequence();

        // sender waits until every key word has come out
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_keys.size() != 0);

        tx_gaps = 1'b1;
        rx_odds = 50;
        while (bytes_sent < TOTAL_BYTES) random_sequence();

        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_keys.size() != 0);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("terminal_key_decoder_top regression: pass");
        end else begin
            $display("terminal_key_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/tkd_pkg.sv
hdl/tkd_step.sv
hdl/terminal_key_decoder_top.sv
tb/sv/terminal_key_decoder_top_tb.sv
